FILE: hw/rtl/ppou_pkg.sv
package ppou_pkg;

	// Operation select codes held in the mode register
	typedef enum logic [2:0] {
		MODE_NEGATE    = 3'd0,
		MODE_GRAY      = 3'd1,
		MODE_CONTR_UP  = 3'd2,
		MODE_CONTR_DN  = 3'd3,
		MODE_RED_BOOST = 3'd4,
		MODE_GRN_BOOST = 3'd5,
		MODE_BLU_BOOST = 3'd6,
		MODE_BLEND     = 3'd7
	} mode_t;

	// Configuration register indexes
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT = 1'b1;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned WEIGHT_W = 9;
	localparam logic [CH_W-1:0]     CH_MAX      = 8'd255;
	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 9'd256;

	// Divide by 3 of a sum up to 765: multiply by 683 and shift by 11
	localparam logic [9:0] GRAY_RECIP = 10'd683;
	localparam int unsigned GRAY_SHIFT = 11;

	typedef struct packed {
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] second_blue;
		logic [CH_W-1:0] second_green;
		logic [CH_W-1:0] second_red;
	} pixel_in_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] red_out;
	} pixel_out_t;

endpackage

FILE: hw/rtl/ppou_alu.sv
module ppou_alu
	import ppou_pkg::*;
(
	input  mode_t                mode,
	input  logic [WEIGHT_W-1:0]  weight,
	input  pixel_in_t            pix,
	output pixel_out_t           res
);

	function automatic logic [CH_W-1:0] sat8(input logic [9:0] v);
		return (v > 10'(CH_MAX)) ? CH_MAX : v[CH_W-1:0];
	endfunction

	logic [CH_W-1:0]     c [3];
	logic [CH_W-1:0]     s [3];
	logic [CH_W-1:0]     r [3];
	logic [CH_W-1:0]     neg_v [3];
	logic [CH_W-1:0]     up_v [3];
	logic [CH_W-1:0]     dn_v [3];
	logic [CH_W-1:0]     bst_v [3];
	logic [CH_W-1:0]     bld_v [3];
	logic [9:0]          tri_v [3];
	logic [16:0]         prod [3];
	logic [17:0]         bsum [3];
	logic [WEIGHT_W-1:0] w_clamp;
	logic [WEIGHT_W-1:0] w_inv;
	logic [9:0]          gsum;
	logic [19:0]         gprod;
	logic [CH_W-1:0]     gray;

	assign c[0] = pix.blue_in;
	assign c[1] = pix.green_in;
	assign c[2] = pix.red_in;
	assign s[0] = pix.second_blue;
	assign s[1] = pix.second_green;
	assign s[2] = pix.second_red;

	assign w_clamp = (weight > FULL_WEIGHT) ? FULL_WEIGHT : weight;
	assign w_inv   = FULL_WEIGHT - w_clamp;

	assign gsum  = 10'(c[0]) + 10'(c[1]) + 10'(c[2]);
	assign gprod = gsum * GRAY_RECIP;
	assign gray  = gprod[GRAY_SHIFT +: CH_W];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_v[i] = CH_MAX - c[i];
			up_v[i]  = sat8(10'(c[i]) + 10'(c[i] >> 2));
			tri_v[i] = {1'b0, c[i], 1'b0} + 10'(c[i]);
			dn_v[i]  = tri_v[i][9:2];
			bst_v[i] = sat8(10'(c[i]) + 10'(c[i] >> 1));
			prod[i]  = w_inv * c[i];
			bsum[i]  = 18'(prod[i]) + {2'b00, s[i], 8'h00};
			bld_v[i] = sat8({1'b0, bsum[i][17:9]});
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r[i] = c[i];
		end
		unique case (mode)
			MODE_NEGATE: begin
				for (int i = 0; i < 3; i++) r[i] = neg_v[i];
			end
			MODE_GRAY: begin
				for (int i = 0; i < 3; i++) r[i] = gray;
			end
			MODE_CONTR_UP: begin
				for (int i = 0; i < 3; i++) r[i] = up_v[i];
			end
			MODE_CONTR_DN: begin
				for (int i = 0; i < 3; i++) r[i] = dn_v[i];
			end
			MODE_RED_BOOST: r[2] = bst_v[2];
			MODE_GRN_BOOST: r[1] = bst_v[1];
			MODE_BLU_BOOST: r[0] = bst_v[0];
			MODE_BLEND: begin
				for (int i = 0; i < 3; i++) r[i] = bld_v[i];
			end
			default: begin
				for (int i = 0; i < 3; i++) r[i] = c[i];
			end
		endcase
	end

	assign res.blue_out  = r[0];
	assign res.green_out = r[1];
	assign res.red_out   = r[2];

endmodule

FILE: hw/rtl/pixel_point_operation_unit.sv
// Channel   Signals                              Direction  Transaction
// command   start, busy, pixel_in                in         start & !busy
// result    result_valid, result                 out        result_valid (one cycle)
// config    wr_en, wr_index, wr_data             in         wr_en
//
// One pixel per cycle, sustained. The pixel is captured in the input register,
// then the point operation fills the result register.
// busy never rises: the datapath is a plain two-stage pipeline with no stall.
// Reset clears the mode and blend weight to zero and drops all valid bits.
// The result is shown for exactly one cycle; the receiver cannot hold it off.
module pixel_point_operation_unit
	import ppou_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pixel_in_t            pixel_in,
	output logic                 result_valid,
	output pixel_out_t           result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [WEIGHT_W-1:0]  wr_data
);

	mode_t               mode_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic       valid_s1;
	pixel_in_t  pix_s1;
	logic       valid_s2;
	pixel_out_t res_s2;
	pixel_out_t res_comb;

	logic accept;

	// No back-pressure anywhere, so the block is always ready.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Config writes: user must write only while idle (unenforced); no snapshot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NEGATE;
			weight_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:   mode_q   <= mode_t'(wr_data[2:0]);
				REG_WEIGHT: weight_q <= wr_data;
				default:    ;
			endcase
		end
	end

	// Stage 1: capture the incoming transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel_in;
		end
	end

	ppou_alu u_alu (
		.mode   (mode_q),
		.weight (weight_q),
		.pix    (pix_s1),
		.res    (res_comb)
	);

	// Stage 2: hold the result for its single strobe cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

endmodule

FILE: bench/tb.sv
module tb;
	import ppou_pkg::*;

	// Generous limit: about 1150 pixels with random gaps between bursts, even
	// with the drain pauses between phases, finish well inside it.
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned RAND_PHASES   = 24;
	localparam int unsigned PHASE_PIXELS  = 48;
	localparam int unsigned SETTLE_CYCLES = 6;

	// One entry of the command queue: a pixel, or a marker that makes the
	// driver hold off until every outstanding result has come back.
	typedef struct packed {
		logic      drain;
		pixel_in_t px;
	} pixel_cmd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	pixel_in_t            pixel_in;
	logic                 result_valid;
	pixel_out_t           result;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [WEIGHT_W-1:0]  wr_data;

	pixel_cmd_t pixel_cmd_q[$];
	pixel_out_t expected_pixel_q[$];

	// Shadow copy of the two configuration registers
	mode_t               mode_cfg;
	logic [WEIGHT_W-1:0] weight_cfg;

	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned gap_left;

	pixel_point_operation_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel_in    (pixel_in),
		.result_valid(result_valid),
		.result      (result),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	always #10 clk = ~clk;

	// Clamp an intermediate value to the 8-bit channel range
	function automatic int unsigned clamp_ch(input int unsigned v);
		return (v > CH_MAX) ? CH_MAX : v;
	endfunction

	// Expected output pixel for one input pixel under the given configuration.
	// Index 0 is blue, 1 green, 2 red, for both the first and second pixel.
	function automatic pixel_out_t point_op_result(input pixel_in_t px, input mode_t op,
			input logic [WEIGHT_W-1:0] wt);
		int unsigned a [3];
		int unsigned s [3];
		int unsigned r [3];
		int unsigned eff_w;
		int unsigned lum;
		pixel_out_t  po;
		a[0] = px.blue_in;
		a[1] = px.green_in;
		a[2] = px.red_in;
		s[0] = px.second_blue;
		s[1] = px.second_green;
		s[2] = px.second_red;
		foreach (r[i]) r[i] = a[i];
		// Weights past full scale act as full scale: first pixel drops out
		eff_w = (wt > FULL_WEIGHT) ? FULL_WEIGHT : wt;
		case (op)
			MODE_NEGATE: begin
				foreach (r[i]) r[i] = CH_MAX - a[i];
			end
			MODE_GRAY: begin
				lum = (a[0] + a[1] + a[2]) / 3;
				foreach (r[i]) r[i] = lum;
			end
			MODE_CONTR_UP: begin
				foreach (r[i]) r[i] = clamp_ch((5 * a[i]) / 4);
			end
			MODE_CONTR_DN: begin
				foreach (r[i]) r[i] = (3 * a[i]) / 4;
			end
			MODE_RED_BOOST: begin
				r[2] = clamp_ch(a[2] + a[2] / 2);
			end
			MODE_GRN_BOOST: begin
				r[1] = clamp_ch(a[1] + a[1] / 2);
			end
			MODE_BLU_BOOST: begin
				r[0] = clamp_ch(a[0] + a[0] / 2);
			end
			default: begin
				// Blend: first pixel scaled by (256 - w)/256, both halved
				foreach (r[i]) r[i] = clamp_ch(((FULL_WEIGHT - eff_w) * a[i]
					+ FULL_WEIGHT * s[i]) / 512);
			end
		endcase
		po.blue_out  = r[0][CH_W-1:0];
		po.green_out = r[1][CH_W-1:0];
		po.red_out   = r[2][CH_W-1:0];
		return po;
	endfunction

	// Random channel value, biased toward the extremes of the range
	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CH_MAX;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Random blend weight, covering zero, full scale and above full scale
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return FULL_WEIGHT;
			2: return WEIGHT_W'($urandom_range(257, 511));
			3: return '1;
			4: return WEIGHT_W'(1);
			default: return WEIGHT_W'($urandom_range(0, 256));
		endcase
	endfunction

	task automatic queue_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] r, input logic [CH_W-1:0] sb,
			input logic [CH_W-1:0] sg, input logic [CH_W-1:0] sr);
		pixel_cmd_t cmd;
		cmd.drain           = 1'b0;
		cmd.px.blue_in      = b;
		cmd.px.green_in     = g;
		cmd.px.red_in       = r;
		cmd.px.second_blue  = sb;
		cmd.px.second_green = sg;
		cmd.px.second_red   = sr;
		pixel_cmd_q.push_back(cmd);
	endtask

	task automatic queue_drain();
		pixel_cmd_t cmd;
		cmd.drain = 1'b1;
		cmd.px    = '0;
		pixel_cmd_q.push_back(cmd);
	endtask

	// Wait until every queued pixel is accepted and every result is back
	task automatic wait_idle();
		while (pixel_cmd_q.size() != 0 || expected_pixel_q.size() != 0)
			@(posedge clk);
	endtask

	// Write one register on the falling edge; the block takes it at the next
	// rising edge. Only called while the block is idle.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [WEIGHT_W-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == REG_MODE)
			mode_cfg = mode_t'(val[2:0]);
		else
			weight_cfg = val;
		// Leave the falling edge so new pixels never race the driver
		@(posedge clk);
	endtask

	// Driver: present the head of the command queue at the falling edge.
	// Work in bursts of random length separated by random gaps; a drain
	// marker holds the command channel until all results are in.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (gap_left != 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pixel_cmd_q.size() == 0) begin
			start <= 1'b0;
		end else if (pixel_cmd_q[0].drain) begin
			start <= 1'b0;
			if (expected_pixel_q.size() == 0)
				pixel_cmd_q.pop_front();
		end else begin
			start    <= 1'b1;
			pixel_in <= pixel_cmd_q[0].px;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				// About a quarter of the bursts run straight into the next one
				gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// Monitor: check the result of this cycle first, then record the
	// transaction accepted at this edge, so the order within the edge is fixed.
	always @(posedge clk) begin : monitor
		pixel_out_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_pixel_q.size() == 0) begin
					$error("result with nothing outstanding: %h", result);
					err_count++;
				end else begin
					want = expected_pixel_q.pop_front();
					if (result.blue_out !== want.blue_out) begin
						$error("blue_out: expected %0d, actual %0d",
							want.blue_out, result.blue_out);
						err_count++;
					end
					if (result.green_out !== want.green_out) begin
						$error("green_out: expected %0d, actual %0d",
							want.green_out, result.green_out);
						err_count++;
					end
					if (result.red_out !== want.red_out) begin
						$error("red_out: expected %0d, actual %0d",
							want.red_out, result.red_out);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				expected_pixel_q.push_back(point_op_result(pixel_in, mode_cfg, weight_cfg));
				pixel_cmd_q.pop_front();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned nphase;
		logic [WEIGHT_W-1:0] blend_wts [3];
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		pixel_in    = '0;
		wr_en       = 1'b0;
		wr_index    = REG_MODE;
		wr_data     = '0;
		mode_cfg    = MODE_NEGATE;
		weight_cfg  = '0;
		err_count   = 0;
		cycle_count = 0;
		burst_left  = 1;
		gap_left    = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every single-pixel mode on black, white and a mixed pixel.
		// The second pixel differs from the first to show that it is ignored.
		write_reg(REG_WEIGHT, '0);
		for (int m = MODE_NEGATE; m <= MODE_BLU_BOOST; m++) begin
			write_reg(REG_MODE, WEIGHT_W'(m));
			queue_pixel('0, '0, '0, CH_MAX, CH_MAX, CH_MAX);
			queue_pixel(CH_MAX, CH_MAX, CH_MAX, '0, '0, '0);
			// Boosts: 1 stays 1, 128 lands exact at 192, 170 just reaches 255
			queue_pixel(8'h01, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'hFE);
			wait_idle();
		end

		// Directed blend: zero weight, full weight, weight past full scale
		write_reg(REG_MODE, WEIGHT_W'(MODE_BLEND));
		blend_wts[0] = '0;
		blend_wts[1] = FULL_WEIGHT;
		blend_wts[2] = '1;
		foreach (blend_wts[k]) begin
			write_reg(REG_WEIGHT, blend_wts[k]);
			queue_pixel(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX);
			if (k == 0)
				queue_pixel(CH_MAX, 8'h80, '0, '0, 8'h81, CH_MAX);
			wait_idle();
		end

		// Random phases: a fresh configuration each, blend favored since it
		// is the only mode that uses both pixels and the weight.
		for (nphase = 0; nphase < RAND_PHASES; nphase++) begin
			if ($urandom_range(0, 9) >= 8)
				write_reg(REG_MODE, WEIGHT_W'(MODE_BLEND));
			else
				write_reg(REG_MODE, WEIGHT_W'($urandom_range(MODE_NEGATE, MODE_BLEND)));
			if (nphase == 0 || $urandom_range(0, 1) == 1)
				write_reg(REG_WEIGHT, pick_weight());
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// Pause mid-stream now and then until all results drain
				if ((nphase == 0 && n == PHASE_PIXELS / 2) || $urandom_range(0, 99) == 0)
					queue_drain();
				queue_pixel(pick_channel(), pick_channel(), pick_channel(),
					pick_channel(), pick_channel(), pick_channel());
			end
			wait_idle();
		end

		// Let any stray result show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
